FILE: hdl/pls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and codes for the positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned POS_W    = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned LEN_W    = 7;

    // operation codes
    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_END   = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_END   = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BEYOND   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_DEL,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

FILE: hdl/pls_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pls_ram
// Generic simple dual-port ram, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pls_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: hdl/positional_list_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_store
// Packed ordered list of signed words with positional insert and delete.
// ----------------------------------------------------------------------------
// sequence: insert at index k shifts entries k and up one place up, then writes k;
//   delete at k reads entry k, shifts the rest down; failed or unused ops go to the result
// throughput: one item at a time; the shift loop moves one entry per cycle
//   through the single ram read and write port
// reset: i_rst_n synchronous active low clears the length, sequencer and output
//   valid; ram contents are not cleared, only entries below the length are read
module positional_list_store #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input transfer
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [47:0]  s_tdata,   // op[2:0], value[34:3], position[42:35], zero pad
    // result transfer
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata    // status[2:0], removed_value[34:3], length[41:35], zero pad
);

    import pls_pkg::*;

    localparam int unsigned CW   = $clog2(CAPACITY + 1);      // count width
    localparam int unsigned AW   = $clog2(CAPACITY);          // ram address width
    localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    // input fields
    logic [OP_W-1:0]   w_op;
    logic [WORD_W-1:0] w_value;
    logic [POS_W-1:0]  w_pos;

    assign w_op    = s_tdata[2:0];
    assign w_value = s_tdata[34:3];
    assign w_pos   = s_tdata[42:35];

    // sequencer state
    t_state             r_state, n_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_ptr;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      r_lim;
    logic [WORD_W-1:0]  r_word;
    logic [STATUS_W-1:0] r_stat;
    logic [WORD_W-1:0]  r_rem;

    // read pipeline: what to do with the ram data when it arrives in the cycle after the read
    logic               r_pend_wr;
    logic               r_pend_cap;
    logic [AW-1:0]      r_waddr;

    // result register
    logic               r_out_vld;
    logic [STATUS_W-1:0] r_out_stat;
    logic [WORD_W-1:0]  r_out_rem;
    logic [LEN_W-1:0]   r_out_len;

    logic w_accept;
    logic w_out_free;

    assign s_tready   = (r_state == S_IDLE);
    assign w_accept   = s_tvalid && s_tready;
    assign w_out_free = !r_out_vld || m_tready;

    // ------------------------------------------------------------------------
    // decode of an accepted item
    // ------------------------------------------------------------------------
    logic [CMPW-1:0]     w_pos_e, w_cnt_e, w_pos_m1;
    logic [CW-1:0]       w_cnt_m1;
    t_state              d_next;
    logic [STATUS_W-1:0] d_stat;
    logic [CW-1:0]       d_idx;
    logic [CW-1:0]       d_count;

    assign w_pos_e  = CMPW'(w_pos);
    assign w_cnt_e  = CMPW'(r_count);
    assign w_pos_m1 = w_pos_e - CMPW'(1);
    assign w_cnt_m1 = r_count - CW'(1);

    always_comb begin
        d_next  = S_DONE;
        d_stat  = ST_OK;
        d_idx   = '0;
        d_count = r_count;
        unique case (w_op)
            OP_INS_FRONT, OP_INS_END, OP_INS_POS: begin
                if (r_count >= CW'(CAPACITY)) begin
                    // store full, item dropped
                    d_stat = ST_FULL;
                end else begin
                    d_next  = S_INS;
                    d_count = r_count + CW'(1);
                    if (w_op == OP_INS_FRONT ||
                        (w_op == OP_INS_POS && w_pos_e <= CMPW'(1))) begin
                        d_idx = '0;
                    end else if (w_op == OP_INS_END) begin
                        d_idx = r_count;
                    end else if (w_pos_e > w_cnt_e + CMPW'(1)) begin
                        // past the end: append and flag it
                        d_idx  = r_count;
                        d_stat = ST_APPENDED;
                    end else begin
                        d_idx = w_pos_m1[CW-1:0];
                    end
                end
            end
            OP_DEL_FRONT, OP_DEL_END, OP_DEL_POS: begin
                if (r_count == '0) begin
                    d_stat = ST_EMPTY;
                end else if (w_op == OP_DEL_FRONT ||
                             (w_op == OP_DEL_POS && w_pos_e <= CMPW'(1))) begin
                    d_next  = S_DEL;
                    d_idx   = '0;
                    d_count = w_cnt_m1;
                end else if (w_op == OP_DEL_END) begin
                    d_next  = S_DEL;
                    d_idx   = w_cnt_m1;
                    d_count = w_cnt_m1;
                end else if (w_pos_e > w_cnt_e) begin
                    d_stat = ST_BEYOND;
                end else begin
                    d_next  = S_DEL;
                    d_idx   = w_pos_m1[CW-1:0];
                    d_count = w_cnt_m1;
                end
            end
            default: begin
                // unused op codes change nothing
                d_stat = ST_OK;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------------
    logic w_ins_more;
    logic w_del_more;
    logic [CW-1:0] w_ptr_m1;

    assign w_ins_more = (r_ptr > r_idx);
    assign w_del_more = (r_ptr < r_lim);
    assign w_ptr_m1   = r_ptr - CW'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = d_next;
            S_INS:  if (!w_ins_more) n_state = S_PUT;
            S_PUT:  n_state = S_DONE;
            S_DEL:  if (!w_del_more) n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // sequencer outputs: ram read, read pipeline setup, ram write
    // ------------------------------------------------------------------------
    logic               c_rd_issue;
    logic               c_rd_cap;
    logic [AW-1:0]      c_raddr;
    logic [AW-1:0]      c_pend_addr;
    logic               c_we;
    logic [AW-1:0]      c_waddr;
    logic [WORD_W-1:0]  c_wdata;
    logic [WORD_W-1:0]  w_rdata;

    always_comb begin
        c_rd_issue  = 1'b0;
        c_rd_cap    = 1'b0;
        c_raddr     = '0;
        c_pend_addr = '0;
        unique case (r_state)
            S_INS: begin
                // move entry ptr-1 up to ptr
                if (w_ins_more) begin
                    c_rd_issue  = 1'b1;
                    c_raddr     = w_ptr_m1[AW-1:0];
                    c_pend_addr = r_ptr[AW-1:0];
                end
            end
            S_DEL: begin
                // first read is the removed word, the rest move down by one
                if (w_del_more) begin
                    c_rd_issue  = 1'b1;
                    c_rd_cap    = (r_ptr == r_idx);
                    c_raddr     = r_ptr[AW-1:0];
                    c_pend_addr = w_ptr_m1[AW-1:0];
                end
            end
            default: begin
                c_rd_issue = 1'b0;
            end
        endcase

        if (r_state == S_PUT) begin
            c_we    = 1'b1;
            c_waddr = r_idx[AW-1:0];
            c_wdata = r_word;
        end else begin
            c_we    = r_pend_wr;
            c_waddr = r_waddr;
            c_wdata = w_rdata;
        end
    end

    pls_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (c_raddr),
        .o_rdata (w_rdata)
    );

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    logic [CW+LEN_W-1:0] w_len_ext;
    assign w_len_ext = {{LEN_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_pend_wr  <= 1'b0;
            r_pend_cap <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend_wr  <= c_rd_issue && !c_rd_cap;
            r_pend_cap <= c_rd_issue && c_rd_cap;

            if (w_accept) begin
                r_count <= d_count;
            end

            // result valid is set from the done state and drops once the downstream side takes it
            if (r_state == S_DONE && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_waddr <= c_pend_addr;

        if (w_accept) begin
            r_word <= w_value;
            r_stat <= d_stat;
            r_idx  <= d_idx;
            r_lim  <= r_count;
            r_rem  <= '0;
            // insert walks down from the end, delete walks up from the index
            r_ptr  <= (d_next == S_INS) ? r_count : d_idx;
        end else begin
            if (r_state == S_INS && w_ins_more) begin
                r_ptr <= w_ptr_m1;
            end else if (r_state == S_DEL && w_del_more) begin
                r_ptr <= r_ptr + CW'(1);
            end
            if (r_pend_cap) begin
                r_rem <= w_rdata;
            end
        end

        if (r_state == S_DONE && w_out_free) begin
            r_out_stat <= r_stat;
            r_out_rem  <= r_rem;
            r_out_len  <= w_len_ext[LEN_W-1:0];
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = {6'd0, r_out_len, r_out_rem, r_out_stat};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("list length above capacity");

    a_put_at_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |-> (r_ptr == r_idx))
        else $error("insert slot written before shift finished");

    a_pend_in_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_wr || r_pend_cap) |-> (r_state == S_INS || r_state == S_DEL))
        else $error("ram read data used outside a shift loop");

    a_cap_in_delete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_cap |-> (r_state == S_DEL && $past(r_ptr) == r_idx))
        else $error("removed word captured at wrong index");

endmodule
`default_nettype wire
